### sv/oef_pkg.sv
// Shared types and constants for the oriented edge feature block.
// Used by oef_window, oef_calc and oriented_edge_features_3x3; no dependencies.
package oef_pkg;

	// pixel and window storage
	typedef logic [7:0] pixel_t;
	typedef logic [8:0][7:0] window_t;

	// register indexes on the configuration port
	localparam logic [1:0] REG_REGION_SIZE       = 2'd0;
	localparam logic [1:0] REG_ORIENTATION_COUNT = 2'd1;
	localparam logic [1:0] REG_EDGE_THRESHOLD    = 2'd2;

	// register reset values
	localparam logic [4:0]  REGION_SIZE_RST       = 5'd7;
	localparam logic [3:0]  ORIENTATION_COUNT_RST = 4'd4;
	localparam logic [17:0] EDGE_THRESHOLD_RST    = 18'd52224;

	// orientation count steps
	localparam logic [3:0] ORIENT_FOUR  = 4'd4;
	localparam logic [3:0] ORIENT_EIGHT = 4'd8;

	// weights in units of 1/1024, at the width of the weighted sums
	localparam int PROD_W = 20;
	localparam logic signed [PROD_W-1:0] WEIGHT_MAJOR = 20'sd946;
	localparam logic signed [PROD_W-1:0] WEIGHT_MINOR = 20'sd392;

	// stage 1 control: window holds a result candidate plus its position
	typedef struct packed {
		logic       valid;
		logic [3:0] row;
		logic [3:0] col;
		logic       last;
	} stage_t;

	// one result item
	typedef struct packed {
		logic [17:0] mag_horizontal;
		logic [17:0] mag_vertical;
		logic [17:0] mag_diag_down;
		logic [17:0] mag_diag_up;
		logic [18:0] mag_angle_a;
		logic [18:0] mag_angle_b;
		logic [18:0] mag_angle_c;
		logic [18:0] mag_angle_d;
		logic [7:0]  above_mask;
		logic [3:0]  center_row;
		logic [3:0]  center_col;
		logic        last_of_region;
	} result_t;

endpackage

### sv/oef_window.sv
// Line buffer memory, 3x3 window and raster position counters.
// Depends on oef_pkg for the pixel, window and stage types.
module oef_window #(
	parameter int MAX_REGION_SIZE = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_accept,
	input  oef_pkg::pixel_t pixel,
	input  logic            s1_take,
	input  logic            counter_clear,
	input  logic [4:0]      region_size,
	output oef_pkg::window_t window_s1,
	output oef_pkg::stage_t  stage_s1
);

	localparam int CNT_W = $clog2(MAX_REGION_SIZE);
	localparam int SW    = (CNT_W + 1 > 5) ? CNT_W + 1 : 5;

	logic [CNT_W-1:0] col_q, row_q, col_d, row_d;
	logic [SW-1:0]    side, col_ext, row_ext, col_inc, row_inc, region_ext;
	logic             produce, last_px;

	// line memory word: middle row in the high byte, upper row in the low byte
	logic [15:0] line_mem [MAX_REGION_SIZE];
	logic [15:0] rd_q;

	// effective side length
	always_comb begin
		region_ext = SW'(region_size);
		if (region_ext == '0) begin
			side = SW'(1);
		end else if (region_ext > SW'(MAX_REGION_SIZE)) begin
			side = SW'(MAX_REGION_SIZE);
		end else begin
			side = region_ext;
		end
	end

	// next raster position
	always_comb begin
		col_ext = SW'(col_q);
		row_ext = SW'(row_q);
		col_inc = col_ext + SW'(1);
		row_inc = row_ext + SW'(1);
		col_d   = col_q;
		row_d   = row_q;
		if (counter_clear) begin
			col_d = '0;
			row_d = '0;
		end else if (in_accept) begin
			if (col_inc >= side) begin
				col_d = '0;
				row_d = (row_inc >= side) ? '0 : CNT_W'(row_inc);
			end else begin
				col_d = CNT_W'(col_inc);
			end
		end
	end

	assign produce = (row_ext >= SW'(2)) && (col_ext >= SW'(2));
	assign last_px = (row_ext == side - SW'(1)) && (col_ext == side - SW'(1));

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

	// line memory, read prefetched at the column of the next pixel
	always_ff @(posedge clk) begin
		if (in_accept) begin
			line_mem[col_q] <= {pixel, rd_q[15:8]};
		end
		if (in_accept && (col_d == col_q)) begin
			rd_q <= {pixel, rd_q[15:8]};
		end else begin
			rd_q <= line_mem[col_d];
		end
	end

	// window shift, stage 1 control and position of the window center
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_s1 <= '0;
			stage_s1  <= '0;
		end else if (in_accept) begin
			window_s1[0]   <= window_s1[1];
			window_s1[1]   <= window_s1[2];
			window_s1[2]   <= rd_q[7:0];
			window_s1[3]   <= window_s1[4];
			window_s1[4]   <= window_s1[5];
			window_s1[5]   <= rd_q[15:8];
			window_s1[6]   <= window_s1[7];
			window_s1[7]   <= window_s1[8];
			window_s1[8]   <= pixel;
			stage_s1.valid <= produce;
			stage_s1.row   <= 4'(row_ext - SW'(1));
			stage_s1.col   <= 4'(col_ext - SW'(1));
			stage_s1.last  <= last_px;
		end else if (s1_take) begin
			stage_s1.valid <= 1'b0;
		end
	end

endmodule

### sv/oef_calc.sv
// Edge magnitudes, orientation gating and threshold mask with result register.
// Depends on oef_pkg for the window, stage and result types and the weights.
module oef_calc (
	input  logic             clk,
	input  logic             load,
	input  oef_pkg::window_t window_s1,
	input  oef_pkg::stage_t  stage_s1,
	input  logic [3:0]       orientation_count,
	input  logic [17:0]      edge_threshold,
	output oef_pkg::result_t result_s2
);

	logic signed [8:0]                 dh, dv, dd, du;
	logic signed [oef_pkg::PROD_W-1:0] dh_x, dv_x;
	logic signed [oef_pkg::PROD_W-1:0] maj_h, min_h, maj_v, min_v;
	logic signed [oef_pkg::PROD_W-1:0] sum_a, sum_b, sum_c, sum_d;
	logic [7:0]                        active;
	logic [7:0][18:0]                  mag;
	logic [7:0][18:0]                  gated;
	logic [7:0]                        mask;

	function automatic logic [7:0] abs9(input logic signed [8:0] v);
		logic signed [8:0] n;
		n = -v;
		return v[8] ? n[7:0] : v[7:0];
	endfunction

	function automatic logic [18:0] abs20(input logic signed [oef_pkg::PROD_W-1:0] v);
		logic signed [oef_pkg::PROD_W-1:0] n;
		n = -v;
		return v[oef_pkg::PROD_W-1] ? n[18:0] : v[18:0];
	endfunction

	// signed differences across the window
	always_comb begin
		dh = $signed({1'b0, window_s1[5]}) - $signed({1'b0, window_s1[3]});
		dv = $signed({1'b0, window_s1[7]}) - $signed({1'b0, window_s1[1]});
		dd = $signed({1'b0, window_s1[0]}) - $signed({1'b0, window_s1[8]});
		du = $signed({1'b0, window_s1[2]}) - $signed({1'b0, window_s1[6]});
	end

	// weighted combinations by constant multiplication
	always_comb begin
		dh_x  = oef_pkg::PROD_W'(dh);
		dv_x  = oef_pkg::PROD_W'(dv);
		maj_h = dh_x * oef_pkg::WEIGHT_MAJOR;
		min_h = dh_x * oef_pkg::WEIGHT_MINOR;
		maj_v = dv_x * oef_pkg::WEIGHT_MAJOR;
		min_v = dv_x * oef_pkg::WEIGHT_MINOR;
		sum_a = maj_h + min_v;
		sum_b = min_h + maj_v;
		sum_c = maj_v - min_h;
		sum_d = min_v - maj_h;
	end

	// magnitudes in units of 1/(255*1024)
	always_comb begin
		mag[0] = {1'b0, abs9(dh), 10'b0};
		mag[1] = {1'b0, abs9(dv), 10'b0};
		mag[2] = {1'b0, abs9(dd), 10'b0};
		mag[3] = {1'b0, abs9(du), 10'b0};
		mag[4] = abs20(sum_a);
		mag[5] = abs20(sum_b);
		mag[6] = abs20(sum_c);
		mag[7] = abs20(sum_d);
	end

	// active orientations: two, four or eight
	always_comb begin
		active      = 8'b0000_0011;
		active[3:2] = (orientation_count >= oef_pkg::ORIENT_FOUR) ? 2'b11 : 2'b00;
		active[7:4] = (orientation_count >= oef_pkg::ORIENT_EIGHT) ? 4'hF : 4'h0;
	end

	// gating and strict threshold compare
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			gated[k] = active[k] ? mag[k] : '0;
			mask[k]  = active[k] && (mag[k] > {1'b0, edge_threshold});
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (load) begin
			result_s2.mag_horizontal <= gated[0][17:0];
			result_s2.mag_vertical   <= gated[1][17:0];
			result_s2.mag_diag_down  <= gated[2][17:0];
			result_s2.mag_diag_up    <= gated[3][17:0];
			result_s2.mag_angle_a    <= gated[4];
			result_s2.mag_angle_b    <= gated[5];
			result_s2.mag_angle_c    <= gated[6];
			result_s2.mag_angle_d    <= gated[7];
			result_s2.above_mask     <= mask;
			result_s2.center_row     <= stage_s1.row;
			result_s2.center_col     <= stage_s1.col;
			result_s2.last_of_region <= stage_s1.last;
		end
	end

endmodule

### sv/oriented_edge_features_3x3.sv
// Top level of the oriented 3x3 edge feature block: stream ports and config registers.
// Depends on oef_pkg, oef_window and oef_calc.
//
// Pixels of a square region enter in raster order, one per clock when the output side
// keeps up; every interior pixel gives one result item, registered after the pixel that
// completes its window: window register, then result register. Each result carries the
// active edge magnitudes, an above-threshold mask and the window center position; tlast
// marks the final interior pixel of the region. The two line buffers share one
// MAX_REGION_SIZE x 16 memory whose read is prefetched at the next column, so the
// sustained rate is one pixel per clock. With a stalled output one more result is held
// in the window stage before s_tready drops. Writing region_size restarts the region.
module oriented_edge_features_3x3 #(
	parameter int MAX_REGION_SIZE = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	// pixel stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] pixel
	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// from bit 0: mag_horizontal(18) mag_vertical(18) mag_diag_down(18) mag_diag_up(18)
	// mag_angle_a(19) mag_angle_b(19) mag_angle_c(19) mag_angle_d(19) above_mask(8)
	// center_row(4) center_col(4), zero fill to 168 bits
	output logic [167:0] m_tdata,
	output logic         m_tlast,   // last_of_region
	// configuration
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [17:0]  cfg_data
);

	logic [4:0]  region_size_q;
	logic [3:0]  orientation_count_q;
	logic [17:0] edge_threshold_q;
	logic        m_tvalid_q;
	logic        in_accept, s1_take, counter_clear;

	oef_pkg::window_t window_s1;
	oef_pkg::stage_t  stage_s1;
	oef_pkg::result_t result_s2;

	// handshake control
	assign s1_take       = stage_s1.valid && (!m_tvalid_q || m_tready);
	assign s_tready      = !stage_s1.valid || s1_take;
	assign in_accept     = s_tvalid && s_tready;
	assign counter_clear = cfg_we && (cfg_index == oef_pkg::REG_REGION_SIZE);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_size_q       <= oef_pkg::REGION_SIZE_RST;
			orientation_count_q <= oef_pkg::ORIENTATION_COUNT_RST;
			edge_threshold_q    <= oef_pkg::EDGE_THRESHOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				oef_pkg::REG_REGION_SIZE:       region_size_q       <= cfg_data[4:0];
				oef_pkg::REG_ORIENTATION_COUNT: orientation_count_q <= cfg_data[3:0];
				oef_pkg::REG_EDGE_THRESHOLD:    edge_threshold_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s1_take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	oef_window #(
		.MAX_REGION_SIZE(MAX_REGION_SIZE)
	) u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_accept    (in_accept),
		.pixel        (s_tdata),
		.s1_take      (s1_take),
		.counter_clear(counter_clear),
		.region_size  (region_size_q),
		.window_s1    (window_s1),
		.stage_s1     (stage_s1)
	);

	oef_calc u_calc (
		.clk              (clk),
		.load             (s1_take),
		.window_s1        (window_s1),
		.stage_s1         (stage_s1),
		.orientation_count(orientation_count_q),
		.edge_threshold   (edge_threshold_q),
		.result_s2        (result_s2)
	);

	// output packing
	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = result_s2.last_of_region;
	assign m_tdata  = {4'b0,
	                   result_s2.center_col,
	                   result_s2.center_row,
	                   result_s2.above_mask,
	                   result_s2.mag_angle_d,
	                   result_s2.mag_angle_c,
	                   result_s2.mag_angle_b,
	                   result_s2.mag_angle_a,
	                   result_s2.mag_diag_up,
	                   result_s2.mag_diag_down,
	                   result_s2.mag_vertical,
	                   result_s2.mag_horizontal};

endmodule
